@@ src/egcd_pkg.sv @@
package egcd_pkg;

  localparam int unsigned OPND_W  = 31;
  localparam int unsigned COEFF_W = 32;
  // Internal coefficient width; leaves headroom for the partial products q*s.
  localparam int unsigned ACC_W   = 34;
  localparam int unsigned CNT_W   = $clog2(OPND_W);

  typedef struct packed {
    logic [OPND_W-1:0] value_a;
    logic [OPND_W-1:0] value_b;
  } egcd_in_t;

  typedef struct packed {
    logic [OPND_W-1:0]         divisor;
    logic signed [COEFF_W-1:0] coeff_x;
    logic signed [COEFF_W-1:0] coeff_y;
    logic [OPND_W-1:0]         inverse;
    logic                      inverse_exists;
  } egcd_out_t;

endpackage

@@ src/extended_gcd_modular_inverse_top.sv @@
// Extended Euclid with modular inverse. Pulse start_i while busy_o is low to
// hand in one operand pair; busy_o stays high until the result beat, which
// shows on res_o for exactly one cycle with done_o high and cannot be held
// off, so the receiver must take it then. Each Euclid step runs a bit-serial
// restoring divider over every dividend bit, then passes through the update
// state and back to the check state, which moves on to finish once r1 is zero.
// A new pair is accepted in the same cycle as the result beat.
module extended_gcd_modular_inverse_top
  import egcd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  egcd_in_t  data_i,
  output logic      done_o,
  output egcd_out_t res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  state_e state_q;

  logic [OPND_W-1:0]       r0_q, r1_q, b_q, dvd_q, rem_q;
  logic signed [ACC_W-1:0] s0_q, s1_q, t0_q, t1_q, acc_s_q, acc_t_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    done_q;
  egcd_out_t               res_q;

  // One restoring division step: bring down the next dividend bit and try
  // to subtract the divisor.
  logic [OPND_W:0]   trial;
  logic [OPND_W+1:0] diff;
  logic              qbit;
  logic [OPND_W-1:0] rem_d;
  logic signed [ACC_W-1:0] acc_s_d, acc_t_d;

  assign trial = {rem_q, dvd_q[OPND_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, r1_q};
  assign qbit  = !diff[OPND_W+1];
  assign rem_d = qbit ? diff[OPND_W-1:0] : trial[OPND_W-1:0];

  // The quotient times each coefficient builds up MSB first with the bits.
  assign acc_s_d = (acc_s_q <<< 1) + (qbit ? s1_q : '0);
  assign acc_t_d = (acc_t_q <<< 1) + (qbit ? t1_q : '0);

  // Final reduction: |x| stays below b whenever the inverse exists.
  logic                    exists;
  logic signed [ACC_W-1:0] inv_full;

  assign exists   = (r0_q == OPND_W'(1)) && (b_q != '0);
  assign inv_full = s0_q[ACC_W-1] ? s0_q + $signed({{(ACC_W-OPND_W){1'b0}}, b_q}) : s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            r0_q    <= data_i.value_a;
            r1_q    <= data_i.value_b;
            b_q     <= data_i.value_b;
            s0_q    <= ACC_W'(1);
            s1_q    <= '0;
            t0_q    <= '0;
            t1_q    <= ACC_W'(1);
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (r1_q == '0) begin
            state_q <= ST_FINISH;
          end else begin
            dvd_q   <= r0_q;
            rem_q   <= '0;
            acc_s_q <= '0;
            acc_t_q <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          dvd_q   <= dvd_q << 1;
          rem_q   <= rem_d;
          acc_s_q <= acc_s_d;
          acc_t_q <= acc_t_d;
          cnt_q   <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(OPND_W - 1)) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          r0_q    <= r1_q;
          r1_q    <= rem_q;
          s0_q    <= s1_q;
          s1_q    <= s0_q - acc_s_q;
          t0_q    <= t1_q;
          t1_q    <= t0_q - acc_t_q;
          state_q <= ST_CHECK;
        end
        ST_FINISH: begin
          res_q.divisor        <= r0_q;
          res_q.coeff_x        <= s0_q[COEFF_W-1:0];
          res_q.coeff_y        <= t0_q[COEFF_W-1:0];
          res_q.inverse        <= exists ? inv_full[OPND_W-1:0] : '0;
          res_q.inverse_exists <= exists;
          done_q               <= 1'b1;
          state_q              <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ src/egcd_checker.sv @@
module egcd_checker
  import egcd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input logic      busy_o,
  input logic      done_o,
  input egcd_out_t res_o
);

  // An accepted beat always starts work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted operands did not raise busy");

  // The result beat ends a busy stretch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && $past(busy_o))
    else $error("result beat outside the end of a busy stretch");

  // One result per item: the strobe is never held high.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // An inverse is only reported for coprime operands: the gcd must be one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.inverse_exists |-> res_o.divisor == OPND_W'(1))
    else $error("inverse flagged with a gcd other than one");

endmodule

bind extended_gcd_modular_inverse_top egcd_checker u_egcd_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);
